@@ src/ws30_pkg.sv @@
package ws30_pkg;

    localparam int BLOCK_BYTES = 32768;
    localparam int MAX_SKIP    = 8;
    localparam int WORD_W      = 16;
    localparam int CLASS_W     = 3;
    localparam int SKIP_W      = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [CLASS_W-1:0] class_t;

    localparam word_t  BLOCK_WORD = word_t'(BLOCK_BYTES);
    localparam class_t RES_LAST   = class_t'(7);

    // Everything the back part needs to expand one prime into its eight results.
    typedef struct packed {
        class_t cls;
        word_t  step;
        word_t  np;
        word_t  prime;
        word_t  offset;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Position in the increment chain at which each residue is reached, per class.
    localparam class_t CHAIN_POS [8][8] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd3, 3'd0, 3'd6, 3'd5, 3'd2, 3'd1, 3'd7, 3'd4},
        '{3'd2, 3'd4, 3'd0, 3'd6, 3'd1, 3'd7, 3'd3, 3'd5},
        '{3'd1, 3'd5, 3'd4, 3'd0, 3'd7, 3'd3, 3'd2, 3'd6},
        '{3'd6, 3'd2, 3'd3, 3'd7, 3'd0, 3'd4, 3'd5, 3'd1},
        '{3'd5, 3'd3, 3'd7, 3'd1, 3'd6, 3'd0, 3'd4, 3'd2},
        '{3'd4, 3'd7, 3'd1, 3'd2, 3'd5, 3'd6, 3'd0, 3'd3},
        '{3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0}
    };

    // Running sum of the per-class corrections along the chain.
    localparam logic [4:0] CHAIN_BIAS [8][8] = '{
        '{5'd0, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
        '{5'd0, 5'd1, 5'd2,  5'd3,  5'd3,  5'd4,  5'd5,  5'd6},
        '{5'd0, 5'd2, 5'd4,  5'd4,  5'd6,  5'd6,  5'd8,  5'd10},
        '{5'd0, 5'd3, 5'd4,  5'd5,  5'd7,  5'd8,  5'd9,  5'd12},
        '{5'd0, 5'd3, 5'd6,  5'd7,  5'd9,  5'd10, 5'd13, 5'd16},
        '{5'd0, 5'd4, 5'd6,  5'd8,  5'd10, 5'd12, 5'd14, 5'd18},
        '{5'd0, 5'd5, 5'd8,  5'd9,  5'd13, 5'd14, 5'd17, 5'd22},
        '{5'd0, 5'd6, 5'd10, 5'd12, 5'd16, 5'd18, 5'd22, 5'd28}
    };

    // One plus twice the running stride multiplier: the mod-30 wheel spokes.
    localparam logic [4:0] WHEEL_MUL [8] = '{
        5'd1, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29
    };

endpackage

@@ src/wheel30_sieve_offsets_core.sv @@
// Channel   Direction  Handshake             Word
// input     in         in_valid / in_stall   one sieving prime: class, stride, repeats,
//                                            prime, stored offset, skipped blocks
// output    out        out_valid / out_stall one residue: index, first and tail offsets,
//                                            advanced offset, last flag
//
// Each prime produces eight output words, one per cycle while the output is not
// stalled. The front part walks the skipped blocks one per cycle, at most eight
// per prime, and takes no new prime until it hands the current one to the queue.
// Reset is asynchronous, active low, and empties the whole pipe. A stall on the
// output freezes the back part only; the front part and the two-entry queue keep
// taking primes until the queue fills.
module wheel30_sieve_offsets_core
    import ws30_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  class_t            residue_class,
    input  word_t             step_bytes,
    input  word_t             repeats,
    input  word_t             prime_value,
    input  word_t             old_offset,
    input  logic [SKIP_W-1:0] skip_blocks,
    output logic              out_valid,
    input  logic              out_stall,
    output class_t            residue_index,
    output word_t             first_offset,
    output word_t             tail_offset,
    output word_t             new_offset,
    output logic              last
);

    // The front part forms n*p at the input, then advances the stored offset
    // through the skipped blocks before handing the prime to the queue.
    logic      push;
    item_t     push_item;
    logic      pop;
    item_t     head_item;
    q_status_t q_status;

    ws30_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .residue_class (residue_class),
        .step_bytes    (step_bytes),
        .repeats       (repeats),
        .prime_value   (prime_value),
        .old_offset    (old_offset),
        .skip_blocks   (skip_blocks),
        .q_status      (q_status),
        .push          (push),
        .push_item     (push_item)
    );

    ws30_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    // The back part visits the residues in index order. Each residue's offset is
    // taken straight from its place in the class chain: the stride times a wheel
    // spoke plus the accumulated class correction, then reduced in two stages.
    ws30_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_item     (head_item),
        .q_status      (q_status),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .residue_index (residue_index),
        .first_offset  (first_offset),
        .tail_offset   (tail_offset),
        .new_offset    (new_offset),
        .last          (last)
    );

endmodule

@@ src/ws30_front.sv @@
module ws30_front
    import ws30_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  class_t    residue_class,
    input  word_t     step_bytes,
    input  word_t     repeats,
    input  word_t     prime_value,
    input  word_t     old_offset,
    input  logic [SKIP_W-1:0] skip_blocks,
    input  q_status_t q_status,
    output logic      push,
    output item_t     push_item
);

    logic              busy_reg, busy_next;
    logic [SKIP_W-1:0] rem_reg, rem_next;
    item_t             item_reg, item_next;
    word_t             gap_reg, gap_next;

    logic              accept;
    logic [SKIP_W-1:0] skip_sat;
    logic [2*WORD_W-1:0] np_full;
    word_t             np;
    word_t             off_dec;
    word_t             off_step;

    assign push     = busy_reg && (rem_reg == '0) && !q_status.full;
    assign in_stall = busy_reg && !push;
    assign accept   = in_valid && !in_stall;

    assign skip_sat = (skip_blocks > SKIP_W'(MAX_SKIP)) ? SKIP_W'(MAX_SKIP) : skip_blocks;
    assign np_full  = {{WORD_W{1'b0}}, repeats} * {{WORD_W{1'b0}}, prime_value};
    assign np       = np_full[WORD_W-1:0];

    // One skipped block per cycle: step back by the unmarked part of a block.
    assign off_dec  = item_reg.offset - gap_reg;
    assign off_step = (off_dec > BLOCK_WORD) ? off_dec + item_reg.prime : off_dec;

    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        item_next = item_reg;
        gap_next  = gap_reg;
        if (accept)
        begin
            busy_next        = 1'b1;
            rem_next         = skip_sat;
            item_next.cls    = residue_class;
            item_next.step   = step_bytes;
            item_next.np     = np;
            item_next.prime  = prime_value;
            item_next.offset = old_offset;
            gap_next         = BLOCK_WORD - np;
        end
        else if (push)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && (rem_reg != '0))
        begin
            rem_next         = rem_reg - SKIP_W'(1);
            item_next.offset = off_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        gap_reg  <= gap_next;
    end

    assign push_item = item_reg;

endmodule

@@ src/ws30_queue.sv @@
module ws30_queue
    import ws30_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output item_t     head_item,
    output q_status_t q_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign q_status.full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/ws30_back.sv @@
module ws30_back
    import ws30_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  item_t     head_item,
    input  q_status_t q_status,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output class_t    residue_index,
    output word_t     first_offset,
    output word_t     tail_offset,
    output word_t     new_offset,
    output logic      last
);

    logic   work_valid_reg, work_valid_next;
    item_t  work_reg, work_next;
    class_t k_reg, k_next;

    logic   s1_valid_reg;
    class_t s1_k_reg;
    word_t  s1_v_reg, s1_np_reg, s1_p_reg, s1_off_reg;

    logic   s2_valid_reg;
    class_t s2_k_reg;
    word_t  s2_first_reg, s2_np_reg, s2_p_reg, s2_off_reg;

    logic   out_valid_reg;
    class_t out_k_reg;
    word_t  out_first_reg, out_tail_reg, out_off_reg;
    logic   out_last_reg;

    logic   adv;
    logic   issue;
    logic   finishing;
    class_t pos;
    logic [WORD_W+4:0] prod;
    word_t  v;
    word_t  first;
    word_t  t_sum;
    word_t  tail;

    // The whole pipe moves together whenever the output register can take a word.
    assign adv       = !out_valid_reg || !out_stall;
    assign issue     = work_valid_reg && adv;
    assign finishing = issue && (k_reg == RES_LAST);
    assign pop       = !q_status.empty && (!work_valid_reg || finishing);

    always_comb
    begin
        work_valid_next = work_valid_reg;
        work_next       = work_reg;
        k_next          = k_reg;
        if (pop)
        begin
            work_valid_next = 1'b1;
            work_next       = head_item;
            k_next          = '0;
        end
        else if (finishing)
        begin
            work_valid_next = 1'b0;
        end
        else if (issue)
        begin
            k_next = k_reg + class_t'(1);
        end
    end

    assign pos  = CHAIN_POS[work_reg.cls][k_reg];
    assign prod = {5'b0, work_reg.step} * {{WORD_W{1'b0}}, WHEEL_MUL[pos]};
    assign v    = work_reg.offset + prod[WORD_W-1:0]
                  + {{(WORD_W-5){1'b0}}, CHAIN_BIAS[work_reg.cls][pos]};

    assign first = (s1_v_reg >= s1_p_reg) ? s1_v_reg - s1_p_reg : s1_v_reg;

    assign t_sum = s2_first_reg + s2_np_reg;
    assign tail  = (t_sum >= BLOCK_WORD) ? t_sum - s2_p_reg : t_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            k_reg          <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            k_reg          <= k_next;
            if (adv)
            begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (adv)
        begin
            s1_k_reg      <= k_reg;
            s1_v_reg      <= v;
            s1_np_reg     <= work_reg.np;
            s1_p_reg      <= work_reg.prime;
            s1_off_reg    <= work_reg.offset;
            s2_k_reg      <= s1_k_reg;
            s2_first_reg  <= first;
            s2_np_reg     <= s1_np_reg;
            s2_p_reg      <= s1_p_reg;
            s2_off_reg    <= s1_off_reg;
            out_k_reg     <= s2_k_reg;
            out_first_reg <= s2_first_reg;
            out_tail_reg  <= tail;
            out_off_reg   <= s2_off_reg;
            out_last_reg  <= (s2_k_reg == RES_LAST);
        end
    end

    assign out_valid     = out_valid_reg;
    assign residue_index = out_k_reg;
    assign first_offset  = out_first_reg;
    assign tail_offset   = out_tail_reg;
    assign new_offset    = out_off_reg;
    assign last          = out_last_reg;

endmodule

@@ src/ws30_checker.sv @@
module ws30_checker
    import ws30_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   out_valid,
    input logic   out_stall,
    input class_t residue_index,
    input word_t  first_offset,
    input word_t  tail_offset,
    input word_t  new_offset,
    input logic   last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(residue_index)
            && $stable(first_offset) && $stable(tail_offset)
            && $stable(new_offset) && $stable(last))
        else $error("output word changed while stalled");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (residue_index == RES_LAST)))
        else $error("last flag does not match the eighth residue");

    a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
            out_valid && (residue_index == $past(residue_index) + class_t'(1)))
        else $error("residues of one prime not delivered back to back in order");

    a_offset_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> new_offset == $past(new_offset))
        else $error("advanced offset changed within one prime");

endmodule

bind wheel30_sieve_offsets_core ws30_checker u_ws30_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .residue_index (residue_index),
    .first_offset  (first_offset),
    .tail_offset   (tail_offset),
    .new_offset    (new_offset),
    .last          (last)
);

@@ tb/wheel30_sieve_offsets_core_tb.sv @@
`timescale 1ns / 100ps

module wheel30_sieve_offsets_core_tb;
    import ws30_pkg::*;

    // One prime as it crosses the input channel.
    typedef struct {
        class_t            cls;
        word_t             step;
        word_t             reps;
        word_t             prime;
        word_t             offset;
        logic [SKIP_W-1:0] skip;
    } prime_word_t;

    // One residue word as it should leave the output channel.
    typedef struct {
        class_t index;
        word_t  first;
        word_t  tail;
        word_t  advanced;
        logic   last;
    } residue_word_t;

    typedef enum logic [1:0] {FLOW_FREE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    // Residue reached at each step of the increment chain, per wheel class.
    localparam logic [2:0] VISIT_ORDER [8][8] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd1, 3'd5, 3'd4, 3'd0, 3'd7, 3'd3, 3'd2, 3'd6},
        '{3'd2, 3'd4, 3'd0, 3'd6, 3'd1, 3'd7, 3'd3, 3'd5},
        '{3'd3, 3'd0, 3'd6, 3'd5, 3'd2, 3'd1, 3'd7, 3'd4},
        '{3'd4, 3'd7, 3'd1, 3'd2, 3'd5, 3'd6, 3'd0, 3'd3},
        '{3'd5, 3'd3, 3'd7, 3'd1, 3'd6, 3'd0, 3'd4, 3'd2},
        '{3'd6, 3'd2, 3'd3, 3'd7, 3'd0, 3'd4, 3'd5, 3'd1},
        '{3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0}
    };

    // Small correction added at each chain step, per wheel class.
    localparam logic [2:0] STEP_CORR [8][7] = '{
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd1, 3'd1, 3'd0, 3'd1, 3'd1, 3'd1},
        '{3'd2, 3'd2, 3'd0, 3'd2, 3'd0, 3'd2, 3'd2},
        '{3'd3, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd3},
        '{3'd3, 3'd3, 3'd1, 3'd2, 3'd1, 3'd3, 3'd3},
        '{3'd4, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4},
        '{3'd5, 3'd3, 3'd1, 3'd4, 3'd1, 3'd3, 3'd5},
        '{3'd6, 3'd4, 3'd2, 3'd4, 3'd2, 3'd4, 3'd6}
    };

    // Number of doubled strides between neighboring wheel spokes.
    localparam int STRIDE_MULT [7] = '{3, 2, 1, 2, 1, 2, 3};

    localparam int HOLD_CYCLES = 400;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    class_t            residue_class = '0;
    word_t             step_bytes = '0;
    word_t             repeats = '0;
    word_t             prime_value = '0;
    word_t             old_offset = '0;
    logic [SKIP_W-1:0] skip_blocks = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    class_t            residue_index;
    word_t             first_offset;
    word_t             tail_offset;
    word_t             new_offset;
    logic              last;

    prime_word_t   primes_to_send [$];
    residue_word_t residues_due [$];
    prime_word_t   on_bus;
    int            primes_total = 0;
    int            primes_taken = 0;
    int            mismatches = 0;
    int            burst_left = 0;
    int            gap_left = 0;
    int            hold_left = 0;
    int            mode_left = 0;
    int            rx_cycles = 0;
    stall_mode_t   stall_mode = FLOW_FREE;

    wheel30_sieve_offsets_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .residue_class(residue_class),
        .step_bytes   (step_bytes),
        .repeats      (repeats),
        .prime_value  (prime_value),
        .old_offset   (old_offset),
        .skip_blocks  (skip_blocks),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .residue_index(residue_index),
        .first_offset (first_offset),
        .tail_offset  (tail_offset),
        .new_offset   (new_offset),
        .last         (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Works out the eight residue words of one prime and queues them in order.
    function automatic void expand_prime(input prime_word_t w);
        word_t         np;
        word_t         off;
        word_t         o;
        word_t         d;
        word_t         v;
        word_t         offs [8];
        int            passes;
        residue_word_t r;

        np = w.reps * w.prime;
        off = w.offset;
        passes = (w.skip > MAX_SKIP) ? MAX_SKIP : int'(w.skip);

        // Each skipped block moves the offset back by the block less the marked span;
        // landing past the block edge pulls it forward by one prime.
        for (int i = 0; i < passes; i++)
        begin
            off = off - (BLOCK_WORD - np);
            if (off > BLOCK_WORD)
                off = off + w.prime;
        end

        o = off + w.step;
        d = w.step << 1;
        offs[VISIT_ORDER[w.cls][0]] = o;
        for (int i = 0; i < 7; i++)
        begin
            o = o + word_t'(STRIDE_MULT[i] * d) + word_t'(STEP_CORR[w.cls][i]);
            offs[VISIT_ORDER[w.cls][i + 1]] = o;
        end

        for (int k = 0; k < 8; k++)
        begin
            v = offs[k];
            if (v >= w.prime)
                v = v - w.prime;
            r.first = v;
            v = v + np;
            if (v >= BLOCK_WORD)
                v = v - w.prime;
            r.index = class_t'(k);
            r.tail = v;
            r.advanced = off;
            r.last = (k == 7);
            residues_due.push_back(r);
        end
    endfunction

    function automatic void queue_prime(input int cls, input int step, input int reps,
                                        input int prime, input int offset, input int skip);
        prime_word_t w;
        w.cls = class_t'(cls);
        w.step = word_t'(step);
        w.reps = word_t'(reps);
        w.prime = word_t'(prime);
        w.offset = word_t'(offset);
        w.skip = SKIP_W'(skip);
        primes_to_send.push_back(w);
    endfunction

    function automatic void compare_field(input string field, input logic [WORD_W-1:0] want,
                                          input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endfunction

    // Sender: offers primes in bursts of random length separated by random gaps.
    // A word that is stalled stays on the bus unchanged until it is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expand_prime(on_bus);
                primes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (primes_to_send.size() > 0)
                begin
                    on_bus = primes_to_send.pop_front();
                    residue_class <= on_bus.cls;
                    step_bytes <= on_bus.step;
                    repeats <= on_bus.reps;
                    prime_value <= on_bus.prime;
                    old_offset <= on_bus.offset;
                    skip_blocks <= on_bus.skip;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                                 : $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls on a random mode, picked anew when its run ends. Twice in the run
    // it holds off for a long stretch so that the block backs up and stalls its input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            rx_cycles++;
            if (rx_cycles == 120 || rx_cycles == 3000)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (stall_mode)
                    FLOW_FREE:   out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Monitor: every word taken is checked against the oldest one still due.
    always @(posedge clk)
    begin
        residue_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (residues_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: word with nothing due, expected none, actual index %0d first %h",
                         $time, residue_index, first_offset);
            end
            else
            begin
                want = residues_due.pop_front();
                compare_field("residue_index", word_t'(want.index), word_t'(residue_index));
                compare_field("first_offset", want.first, first_offset);
                compare_field("tail_offset", want.tail, tail_offset);
                compare_field("new_offset", want.advanced, new_offset);
                compare_field("last", word_t'(want.last), word_t'(last));
            end
        end
    end

    initial
    begin
        word_t p;

        // One ordinary prime per wheel class, with a growing skip.
        for (int c = 0; c < 8; c++)
        begin
            p = word_t'(7 + 30 * (c + 1));
            queue_prime(c, p / 30, BLOCK_BYTES / p, p, 3 * c, c);
        end
        // Full skip and skips past the limit, which saturate.
        queue_prime(5, 9, 118, 277, 100, MAX_SKIP);
        queue_prime(6, 9, 118, 277, 100, 9);
        queue_prime(7, 9, 118, 277, 100, 15);
        // A zero prime adds and subtracts nothing.
        queue_prime(2, 40, 7, 0, 1234, 3);
        // Largest legal prime, and every field at its top, then at its bottom.
        queue_prime(1, 1092, 1, 32768, 0, 1);
        queue_prime(7, 65535, 65535, 65535, 65535, 15);
        queue_prime(0, 0, 0, 0, 0, 0);
        // Offset lands exactly on the block edge, then one past it.
        queue_prime(3, 10, 0, 100, 0, 1);
        queue_prime(4, 10, 0, 100, 1, 1);
        // First offset equal to the prime, then one below it.
        queue_prime(0, 0, 0, 50, 50, 0);
        queue_prime(0, 0, 0, 50, 49, 0);
        // Tail exactly at the block size, then one prime short of it.
        queue_prime(0, 0, 32, 1024, 0, 0);
        queue_prime(0, 0, 31, 1024, 0, 0);

        // Mostly primes shaped as a real sieve would hand them over, the rest raw noise.
        for (int i = 0; i < 400; i++)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                p = word_t'($urandom_range(7, BLOCK_BYTES)) | word_t'(1);
                queue_prime($urandom_range(0, 7), p / 30, BLOCK_BYTES / p, p,
                            $urandom_range(0, p), $urandom_range(0, MAX_SKIP));
            end
            else
            begin
                queue_prime($urandom_range(0, 7), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 15));
            end
        end
        primes_total = primes_to_send.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (primes_taken < primes_total || residues_due.size() != 0)
            @(posedge clk);
        // Let any stray word surface before the verdict.
        repeat (30) @(posedge clk);

        if (mismatches == 0)
            $display("wheel30_sieve_offsets_core_tb: done, clean");
        else
            $display("wheel30_sieve_offsets_core_tb: done, errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("wheel30_sieve_offsets_core_tb: done, errors");
        $finish;
    end

endmodule
